FILE: hdl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Internal widths follow from the geometry
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths fixed by the stream format
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 7;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 16;

  // Character and attribute constants
  localparam int                TAB_STOP    = 4;
  localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL     = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

  // Item kinds carried in tuser
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // One result beat
  typedef struct packed {
    logic [CELL_W-1:0]   cell_word;
    logic [IN_ROW_W-1:0] cursor_row;
    logic [IN_COL_W-1:0] cursor_col;
    logic                done_last;
  } res_t;

  // Screen memory access from the engine
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Physical row of a logical row, given the row held at the top of the screen
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Linear cell address of a physical row and a column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

FILE: hdl/tcw_screen_ram.sv
module tcw_screen_ram (
  input  logic                 clk,
  input  tcw_pkg::ram_req_t    req,
  output logic [tcw_pkg::CELL_W-1:0] q
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q <= mem[req.raddr];
  end

endmodule

FILE: hdl/tcw_engine.sv
module tcw_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::IN_ROW_W-1:0]  read_row,
  input  logic [tcw_pkg::IN_COL_W-1:0]  read_col,
  input  logic                          last_char,
  input  logic [tcw_pkg::CHAR_W-1:0]    text_color,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tcw_pkg::res_t                 res,
  output tcw_pkg::ram_req_t             ram_req,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_q
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_BLANK = 2'd3;

  localparam int COL_W1 = tcw_pkg::COL_W + 1;

  logic [1:0]                   state;
  logic [tcw_pkg::ROW_W-1:0]    cur_row;
  logic [tcw_pkg::COL_W-1:0]    cur_col;
  logic [tcw_pkg::ROW_W-1:0]    top_row;
  logic [tcw_pkg::ADDR_W-1:0]   clr_addr;
  logic [tcw_pkg::COL_W-1:0]    blank_col;
  logic [tcw_pkg::ADDR_W-1:0]   blank_base;
  logic                         rd_ok;

  logic                         accept;
  logic                         is_put;
  logic                         do_write;
  logic                         do_scroll;
  logic                         wrap;
  logic [COL_W1-1:0]            col_inc;
  logic [COL_W1-1:0]            tab_col;
  logic [tcw_pkg::ROW_W-1:0]    cur_row_next;
  logic [tcw_pkg::COL_W-1:0]    cur_col_next;
  logic [tcw_pkg::ROW_W-1:0]    top_row_next;
  logic                         rd_in_range;
  logic [tcw_pkg::ROW_W-1:0]    rd_phys;

  assign in_ready = (state == ST_IDLE) && (!res_valid || res_ready);
  assign accept   = in_valid && in_ready;
  assign is_put   = (mode == tcw_pkg::MODE_PUT);

  // Cursor movement for a put beat
  always_comb begin
    col_inc      = {1'b0, cur_col} + COL_W1'(1);
    tab_col      = COL_W1'(({1'b0, cur_col} / tcw_pkg::TAB_STOP + 1) * tcw_pkg::TAB_STOP);
    wrap         = 1'b0;
    do_write     = 1'b0;
    do_scroll    = 1'b0;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    top_row_next = top_row;
    if (char_code == tcw_pkg::CHAR_TAB) begin
      if (tab_col >= COL_W1'(tcw_pkg::COLUMNS)) begin
        wrap = 1'b1;
      end else begin
        cur_col_next = tab_col[tcw_pkg::COL_W-1:0];
      end
    end else if (char_code == tcw_pkg::CHAR_NL) begin
      wrap = 1'b1;
    end else begin
      do_write = 1'b1;
      if (col_inc >= COL_W1'(tcw_pkg::COLUMNS)) begin
        wrap = 1'b1;
      end else begin
        cur_col_next = col_inc[tcw_pkg::COL_W-1:0];
      end
    end
    if (wrap) begin
      cur_col_next = '0;
      if (cur_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
        // Scrolling moves the top of the screen down one physical row
        do_scroll = 1'b1;
        if (top_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
          top_row_next = '0;
        end else begin
          top_row_next = top_row + tcw_pkg::ROW_W'(1);
        end
      end else begin
        cur_row_next = cur_row + tcw_pkg::ROW_W'(1);
      end
    end
  end

  // Read address for a read beat
  always_comb begin
    rd_in_range = ({1'b0, read_row} < (tcw_pkg::IN_ROW_W+1)'(tcw_pkg::ROWS)) &&
                  ({1'b0, read_col} < (tcw_pkg::IN_COL_W+1)'(tcw_pkg::COLUMNS));
    rd_phys     = tcw_pkg::phys_row(tcw_pkg::ROW_W'(read_row), top_row);
  end

  // Memory port selection: clearing, row blanking, or the put write
  always_comb begin
    ram_req.raddr = tcw_pkg::cell_addr(rd_phys, tcw_pkg::COL_W'(read_col));
    unique case (state)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
      end
      ST_BLANK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = blank_base + tcw_pkg::ADDR_W'(blank_col);
        ram_req.wdata = {text_color, tcw_pkg::BLANK_CHAR};
      end
      default: begin
        ram_req.we    = accept && is_put && do_write;
        ram_req.waddr = tcw_pkg::cell_addr(tcw_pkg::phys_row(cur_row, top_row), cur_col);
        ram_req.wdata = {text_color, char_code};
      end
    endcase
  end

  // Sequencer and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_row   <= '0;
      cur_col   <= '0;
      top_row   <= '0;
      clr_addr  <= '0;
      blank_col <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + tcw_pkg::ADDR_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            if (is_put) begin
              cur_row <= cur_row_next;
              cur_col <= cur_col_next;
              top_row <= top_row_next;
              if (do_scroll) begin
                state     <= ST_BLANK;
                blank_col <= '0;
              end
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        ST_BLANK: begin
          if (blank_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
            state <= ST_IDLE;
          end
          blank_col <= blank_col + tcw_pkg::COL_W'(1);
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Row to blank after a scroll is the old top row; read range flag
  always_ff @(posedge clk) begin
    if (accept) begin
      blank_base <= tcw_pkg::cell_addr(top_row, '0);
      rd_ok      <= rd_in_range;
    end
  end

  // Result register: loaded at a put beat or once read data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && is_put) begin
      res_valid <= 1'b1;
    end else if (state == ST_READ) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_put) begin
      res.cell_word  <= '0;
      res.cursor_row <= tcw_pkg::IN_ROW_W'(cur_row_next);
      res.cursor_col <= tcw_pkg::IN_COL_W'(cur_col_next);
      res.done_last  <= last_char;
    end else if (state == ST_READ) begin
      res.cell_word  <= rd_ok ? ram_q : '0;
      res.cursor_row <= tcw_pkg::IN_ROW_W'(cur_row);
      res.cursor_col <= tcw_pkg::IN_COL_W'(cur_col);
      res.done_last  <= 1'b0;
    end
  end

endmodule

FILE: hdl/text_console_writer.sv
// Text console with an 80 x 25 cell screen held in one block memory and a
// cursor. A put beat (tuser low) writes its byte at the cursor, but tab
// and newline only move it. A put that scrolls the screen is followed by the
// blanking of the new bottom row, one column at a time; the scroll itself is
// a change of the top-row pointer, so no rows are copied. A read beat (tuser
// high) waits on the registered memory read. After reset the memory is
// cleared to grey blanks, one cell a cycle, and no beat is accepted until it
// is done; configuration writes are taken at any time. Each input beat gives
// exactly one output beat, and up to two results can be held waiting for
// m_axis_tready.
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // text_color
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic        s_axis_tuser,  // mode
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cell_word[15:0], cursor_row[20:16], cursor_col[27:21]
  output logic        m_axis_tlast   // done_last
);

  logic [tcw_pkg::CHAR_W-1:0]  text_color;
  logic                        res_valid;
  logic                        res_ready;
  tcw_pkg::res_t               res;
  tcw_pkg::res_t               out_res;
  tcw_pkg::ram_req_t           ram_req;
  logic [tcw_pkg::CELL_W-1:0]  ram_q;

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
    end else if (cfg_wr_en) begin
      text_color <= cfg_wr_data;
    end
  end

  tcw_screen_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .q   (ram_q)
  );

  tcw_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .mode       (s_axis_tuser),
    .char_code  (s_axis_tdata[7:0]),
    .read_row   (s_axis_tdata[12:8]),
    .read_col   (s_axis_tdata[19:13]),
    .last_char  (s_axis_tlast),
    .text_color (text_color),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_req    (ram_req),
    .ram_q      (ram_q)
  );

  // Output register towards the master side
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {4'b0000, out_res.cursor_col, out_res.cursor_row, out_res.cell_word};
  assign m_axis_tlast = out_res.done_last;

  // Every accepted beat has its result in the engine's register: a put loads it
  // directly, and a read loads it in ST_READ from the registered memory read.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> ##[1:2] res_valid)
    else $error("accepted beat produced no result");

  // The engine only takes a beat when its result register can be freed
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!res_valid || res_ready))
    else $error("input accepted while result register blocked");

  // Delivered cursor always lies on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, out_res.cursor_row} < 6'(tcw_pkg::ROWS)) &&
                      ({1'b0, out_res.cursor_col} < 8'(tcw_pkg::COLUMNS)))
    else $error("cursor outside screen");

endmodule
